// ===== hw/rtl/fpbc_pkg.sv =====
// Package for the flow packet and byte counter.
// Holds table sizing, the tuple type and the controller/datapath bundles.
`default_nettype none
package fpbc_pkg;
   localparam int FLOW_ENTRIES = 64;
   localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
   localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
   localparam int TAG_W = 96;
   localparam int CTR_W = 64;

   // Request kinds carried in req_type.
   localparam logic REQ_COUNT  = 1'b0;
   localparam logic REQ_REPORT = 1'b1;

   // Source address, destination address, source port, destination port,
   // packed so that a plain unsigned compare gives the tuple order.
   typedef logic [TAG_W-1:0] tag_type;

   typedef struct packed {
      logic latch;
      logic lookup;
      logic update;
      logic rpt_init;
      logic scan_init;
      logic scan;
      logic fetch;
      logic emit;
      logic emit_empty;
      logic clear;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic last;
      logic scan_done;
      logic rsp_busy;
   } dp_sts_type;
endpackage
`default_nettype wire

// ===== hw/rtl/fpbc_if.sv =====
// Valid/ready channel interfaces for request and response words.
// Stand-alone; no package needed.
`default_nettype none
interface fpbc_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [15:0] src_port;
   logic [15:0] dst_port;
   logic [15:0] pkt_length;
   modport source (output valid, req_type, src_addr, dst_addr, src_port, dst_port,
                   pkt_length, input ready);
   modport sink (input valid, req_type, src_addr, dst_addr, src_port, dst_port,
                 pkt_length, output ready);
endinterface

interface fpbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] flow_src_addr;
   logic [31:0] flow_dst_addr;
   logic [15:0] flow_src_port;
   logic [15:0] flow_dst_port;
   logic [31:0] packet_total;
   logic [31:0] byte_total;
   logic [31:0] dropped_total;
   logic        record_valid;
   logic        last_record;
   modport source (output valid, flow_src_addr, flow_dst_addr, flow_src_port,
                   flow_dst_port, packet_total, byte_total, dropped_total,
                   record_valid, last_record, input ready);
   modport sink (input valid, flow_src_addr, flow_dst_addr, flow_src_port,
                 flow_dst_port, packet_total, byte_total, dropped_total,
                 record_valid, last_record, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fpbc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`default_nettype none
module fpbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/fpbc_datapath.sv =====
// Datapath: tag match array, counter and tag RAMs, sorted-scan logic and
// the response register. Depends on fpbc_pkg, fpbc_if and fpbc_ram.
`default_nettype none
module fpbc_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire fpbc_pkg::dp_cmd_type cmd,
   output fpbc_pkg::dp_sts_type     sts,
   input  wire logic [31:0]         in_src_addr,
   input  wire logic [31:0]         in_dst_addr,
   input  wire logic [15:0]         in_src_port,
   input  wire logic [15:0]         in_dst_port,
   input  wire logic [15:0]         in_pkt_length,
   fpbc_rsp_if.source               rsp
);
   import fpbc_pkg::*;

   tag_type                tag_ff [FLOW_ENTRIES];
   logic [FLOW_ENTRIES-1:0] used_ff;
   tag_type                key_ff;
   logic [15:0]            len_ff;
   logic                   hit_ff, free_ff;
   logic [IDX_W-1:0]       hit_idx_ff, free_idx_ff;
   logic [CNT_W-1:0]       count_ff, emitted_ff, scan_idx_ff;
   logic [31:0]            drop_ff;
   logic                   rv_ff, first_ff, best_found_ff;
   logic [IDX_W-1:0]       pidx_ff, best_idx_ff;
   tag_type                best_tag_ff, last_tag_ff;

   logic                   hit_c, free_c;
   logic [IDX_W-1:0]       hit_idx_c, free_idx_c;
   logic                   ctr_wen, tag_wen;
   logic [IDX_W-1:0]       ctr_waddr, ctr_raddr;
   logic [CTR_W-1:0]       ctr_wdata, ctr_rdata;
   tag_type                tag_rdata;
   logic                   cand_c;

   // Match all stored tuples in parallel; pick first hit and first free entry.
   always_comb begin
      hit_c = 1'b0;
      free_c = 1'b0;
      hit_idx_c = '0;
      free_idx_c = '0;
      for (int i = 0; i < FLOW_ENTRIES; i++) begin
         if (used_ff[i] && tag_ff[i] == key_ff && !hit_c) begin
            hit_c = 1'b1;
            hit_idx_c = IDX_W'(i);
         end
         if (!used_ff[i] && !free_c) begin
            free_c = 1'b1;
            free_idx_c = IDX_W'(i);
         end
      end
   end

   assign ctr_raddr = cmd.fetch ? best_idx_ff : hit_idx_c;
   assign ctr_wen   = cmd.update && (hit_ff || free_ff);
   assign ctr_waddr = hit_ff ? hit_idx_ff : free_idx_ff;
   assign ctr_wdata = hit_ff ? {ctr_rdata[63:32] + 32'd1, ctr_rdata[31:0] + {16'd0, len_ff}}
                             : {32'd1, 16'd0, len_ff};
   assign tag_wen   = cmd.update && !hit_ff && free_ff;

   fpbc_ram #(.WIDTH(CTR_W), .DEPTH(FLOW_ENTRIES)) u_ctr_ram (
      .clock(clock), .wr_en(ctr_wen), .wr_addr(ctr_waddr), .wr_data(ctr_wdata),
      .rd_addr(ctr_raddr), .rd_data(ctr_rdata));

   fpbc_ram #(.WIDTH(TAG_W), .DEPTH(FLOW_ENTRIES)) u_tag_ram (
      .clock(clock), .wr_en(tag_wen), .wr_addr(free_idx_ff), .wr_data(key_ff),
      .rd_addr(scan_idx_ff[IDX_W-1:0]), .rd_data(tag_rdata));

   // A scanned entry is a candidate if it lies above the last reported
   // tuple and below the best found so far in this pass.
   assign cand_c = rv_ff && used_ff[pidx_ff] && (first_ff || tag_rdata > last_tag_ff)
                   && (!best_found_ff || tag_rdata < best_tag_ff);

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         key_ff <= {in_src_addr, in_dst_addr, in_src_port, in_dst_port};
         len_ff <= in_pkt_length;
      end
      if (cmd.lookup) begin
         hit_ff <= hit_c;
         free_ff <= free_c;
         hit_idx_ff <= hit_idx_c;
         free_idx_ff <= free_idx_c;
      end
      if (tag_wen) begin
         tag_ff[free_idx_ff] <= key_ff;
      end
      pidx_ff <= scan_idx_ff[IDX_W-1:0];
      if (cand_c) begin
         best_tag_ff <= tag_rdata;
         best_idx_ff <= pidx_ff;
      end
      if (cmd.emit) begin
         last_tag_ff <= best_tag_ff;
         rsp.flow_src_addr <= best_tag_ff[95:64];
         rsp.flow_dst_addr <= best_tag_ff[63:32];
         rsp.flow_src_port <= best_tag_ff[31:16];
         rsp.flow_dst_port <= best_tag_ff[15:0];
         rsp.packet_total  <= ctr_rdata[63:32];
         rsp.byte_total    <= ctr_rdata[31:0];
         rsp.dropped_total <= drop_ff;
         rsp.record_valid  <= 1'b1;
         rsp.last_record   <= sts.last;
      end else if (cmd.emit_empty) begin
         rsp.flow_src_addr <= '0;
         rsp.flow_dst_addr <= '0;
         rsp.flow_src_port <= '0;
         rsp.flow_dst_port <= '0;
         rsp.packet_total  <= '0;
         rsp.byte_total    <= '0;
         rsp.dropped_total <= drop_ff;
         rsp.record_valid  <= 1'b0;
         rsp.last_record   <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         count_ff <= '0;
         drop_ff <= '0;
         emitted_ff <= '0;
         scan_idx_ff <= '0;
         rv_ff <= 1'b0;
         first_ff <= 1'b1;
         best_found_ff <= 1'b0;
         rsp.valid <= 1'b0;
      end else begin
         if (cmd.update) begin
            if (!hit_ff && free_ff) begin
               used_ff[free_idx_ff] <= 1'b1;
               count_ff <= count_ff + CNT_W'(1);
            end else if (!hit_ff && drop_ff != 32'hFFFF_FFFF) begin
               drop_ff <= drop_ff + 32'd1;
            end
         end
         if (cmd.rpt_init) begin
            emitted_ff <= '0;
            first_ff <= 1'b1;
         end
         if (cmd.scan_init) begin
            scan_idx_ff <= '0;
            rv_ff <= 1'b0;
            best_found_ff <= 1'b0;
         end else if (cmd.scan) begin
            rv_ff <= (scan_idx_ff != CNT_W'(FLOW_ENTRIES));
            if (scan_idx_ff != CNT_W'(FLOW_ENTRIES)) begin
               scan_idx_ff <= scan_idx_ff + CNT_W'(1);
            end
            if (cand_c) begin
               best_found_ff <= 1'b1;
            end
         end
         if (cmd.emit) begin
            emitted_ff <= emitted_ff + CNT_W'(1);
            first_ff <= 1'b0;
         end
         if (cmd.clear) begin
            used_ff <= '0;
            count_ff <= '0;
            drop_ff <= '0;
         end
         if (cmd.emit || cmd.emit_empty) begin
            rsp.valid <= 1'b1;
         end else if (rsp.ready) begin
            rsp.valid <= 1'b0;
         end
      end
   end

   assign sts.empty     = (count_ff == '0);
   assign sts.last      = (emitted_ff + CNT_W'(1) == count_ff);
   assign sts.scan_done = (scan_idx_ff == CNT_W'(FLOW_ENTRIES)) && !rv_ff;
   assign sts.rsp_busy  = rsp.valid;
endmodule
`default_nettype wire

// ===== hw/rtl/fpbc_ctrl.sv =====
// Controller state machine that sequences lookups, updates and reports.
// Depends on fpbc_pkg.
`default_nettype none
module fpbc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_kind,
   output logic                      req_ready,
   output fpbc_pkg::dp_cmd_type      cmd,
   input  wire fpbc_pkg::dp_sts_type sts
);
   import fpbc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOOKUP, ST_UPDATE, ST_SCAN_INIT, ST_SCAN, ST_FETCH,
      ST_EMIT, ST_EMPTY, ST_WAIT_OUT, ST_CLEAR
   } state_type;

   state_type state_ff;
   logic      ready_ff, is_last_ff;
   logic      accept;

   assign accept    = (state_ff == ST_IDLE) && req_valid && ready_ff;
   assign req_ready = ready_ff;

   always_comb begin
      cmd = '0;
      cmd.latch = accept;
      cmd.rpt_init = accept && (req_kind == REQ_REPORT);
      case (state_ff)
         ST_LOOKUP:    cmd.lookup = 1'b1;
         ST_UPDATE:    cmd.update = 1'b1;
         ST_SCAN_INIT: cmd.scan_init = 1'b1;
         ST_SCAN:      cmd.scan = 1'b1;
         ST_FETCH:     cmd.fetch = 1'b1;
         ST_EMIT:      cmd.emit = 1'b1;
         ST_EMPTY:     cmd.emit_empty = 1'b1;
         ST_CLEAR:     cmd.clear = 1'b1;
         default:      cmd.latch = accept;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
         is_last_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  ready_ff <= 1'b0;
                  if (req_kind == REQ_COUNT) begin
                     state_ff <= ST_LOOKUP;
                  end else if (sts.empty) begin
                     state_ff <= ST_EMPTY;
                  end else begin
                     state_ff <= ST_SCAN_INIT;
                  end
               end
            end
            ST_LOOKUP: state_ff <= ST_UPDATE;
            ST_UPDATE: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
            ST_SCAN_INIT: state_ff <= ST_SCAN;
            ST_SCAN: begin
               if (sts.scan_done) begin
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: state_ff <= ST_EMIT;
            ST_EMIT: begin
               is_last_ff <= sts.last;
               state_ff <= ST_WAIT_OUT;
            end
            ST_EMPTY: begin
               is_last_ff <= 1'b1;
               state_ff <= ST_WAIT_OUT;
            end
            ST_WAIT_OUT: begin
               if (!sts.rsp_busy) begin
                  state_ff <= is_last_ff ? ST_CLEAR : ST_SCAN_INIT;
               end
            end
            ST_CLEAR: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/flow_packet_byte_counter_core.sv =====
// Top level of the flow packet and byte counter.
// Depends on fpbc_pkg, fpbc_if, fpbc_ctrl and fpbc_datapath.
//
// Usage: each request word on req_chan either counts one parsed IPv4 packet
// (req_type 0) or asks for a report (req_type 1). A count word looks up its
// four-tuple in a 64-entry flow table whose tags are compared all at once.
// A hit adds one packet and the length to that flow; a miss takes the lowest
// free entry; with the table full the packet is dropped and a saturating drop
// count rises. Count words produce no response word.
// A count word passes through accept, tag match with counter RAM read,
// then the read-modify-write of the counters.
// A report emits one response word per stored flow in ascending tuple order,
// or one word with record_valid low when the table is empty. Each record is
// found by a full pass over the tag RAM.
// After the last word is taken the table and the drop count are cleared.
// One word is handled at a time; req_chan.ready is low while a word is in
// work. When the receiver stalls rsp_chan, the response register holds its
// word and the report waits. Synchronous reset empties the table, clears the
// drop count and returns the block to idle with ready high.
`default_nettype none
module flow_packet_byte_counter_core (
   input  wire logic  clock,
   input  wire logic  reset,
   fpbc_req_if.sink   req_chan,
   fpbc_rsp_if.source rsp_chan
);
   import fpbc_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // The controller only sequences; all table state lives in the datapath.
   fpbc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_kind(req_chan.req_type),
      .req_ready(req_chan.ready), .cmd(cmd), .sts(sts));

   fpbc_datapath u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .in_src_addr(req_chan.src_addr), .in_dst_addr(req_chan.dst_addr),
      .in_src_port(req_chan.src_port), .in_dst_port(req_chan.dst_port),
      .in_pkt_length(req_chan.pkt_length), .rsp(rsp_chan));
endmodule
`default_nettype wire
